// ----- rtl/idct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_pkg
// Shared widths, fixed-point constants and arithmetic helpers for the
// 8x8 row-column inverse DCT.
// ----------------------------------------------------------------------------
package idct_pkg;

    localparam int COEFF_WIDTH   = 12;
    localparam int FRACTION_BITS = 14;
    localparam int OUT_WIDTH     = 12;

    // internal value width: input scaled by 2^FRACTION_BITS plus growth of both passes
    localparam int VW = COEFF_WIDTH + FRACTION_BITS + 8;
    // constant width: largest constant is sqrt(2), signed
    localparam int KW = FRACTION_BITS + 2;
    // width of the shared coefficient / sample store
    localparam int SW = (COEFF_WIDTH > OUT_WIDTH) ? COEFF_WIDTH : OUT_WIDTH;
    // final shift: fraction bits plus the divide by 8
    localparam int FS = FRACTION_BITS + 3;

    typedef logic signed [VW-1:0] vw_t;
    typedef logic signed [KW-1:0] kw_t;

    // constants scaled by 2^30
    localparam longint K30_SQRT2 = 64'sd1518500250;
    localparam longint K30_A     = 64'sd581104888;
    localparam longint K30_B     = 64'sd1402911301;
    localparam longint K30_D     = 64'sd1053110176;
    localparam longint K30_E     = 64'sd209476638;
    localparam longint K30_N     = 64'sd892783698;
    localparam longint K30_T     = 64'sd596538995;

    localparam longint RND30 = 64'sd1 <<< (29 - FRACTION_BITS);
    localparam int     SH30  = 30 - FRACTION_BITS;

    localparam kw_t K_S = kw_t'((K30_SQRT2 + RND30) >>> SH30);
    localparam kw_t K_A = kw_t'((K30_A + RND30) >>> SH30);
    localparam kw_t K_B = kw_t'((K30_B + RND30) >>> SH30);
    localparam kw_t K_D = kw_t'((K30_D + RND30) >>> SH30);
    localparam kw_t K_E = kw_t'((K30_E + RND30) >>> SH30);
    localparam kw_t K_N = kw_t'((K30_N + RND30) >>> SH30);
    localparam kw_t K_T = kw_t'((K30_T + RND30) >>> SH30);

    // product rounded back to FRACTION_BITS fractional bits (half up, floor shift)
    function automatic vw_t cmul(input vw_t v, input kw_t k);
        logic signed [VW+KW-1:0] p;
        p = (VW+KW)'(v) * (VW+KW)'(k);
        p = p + ((VW+KW)'(1) <<< (FRACTION_BITS - 1));
        return p[FRACTION_BITS +: VW];
    endfunction

    // divide by 2^FS toward zero, then clamp to the output range
    function automatic logic signed [SW-1:0] finish(input vw_t v);
        logic signed [VW:0] t;
        logic signed [VW:0] q;
        t = (VW+1)'(v);
        if (v < 0)
        begin
            t = t + (VW+1)'((1 <<< FS) - 1);
        end
        q = t >>> FS;
        if (q > (VW+1)'((1 <<< (OUT_WIDTH - 1)) - 1))
        begin
            q = (VW+1)'((1 <<< (OUT_WIDTH - 1)) - 1);
        end
        else if (q < -(VW+1)'(1 <<< (OUT_WIDTH - 1)))
        begin
            q = -(VW+1)'(1 <<< (OUT_WIDTH - 1));
        end
        return q[SW-1:0];
    endfunction

endpackage

// ----- rtl/idct_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/idct_8x8_two_dimensional.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_8x8_two_dimensional
// 8x8 inverse DCT, row pass then column pass through a transpose RAM,
// samples leave in row-major order.
// ----------------------------------------------------------------------------
// channel  | ports                                | direction
// input    | coefficient, in_valid, in_stall      | in (in_stall out)
// output   | sample, last_of_block, out_valid,    | out (out_stall in)
//          | out_stall                            |
//
// Loading accepts one coefficient per cycle; the 64th starts the transform.
// Each pass handles a line as 8 RAM reads, the read latency, a 4-stage
// butterfly pipeline and 8 RAM writes.
// Each sample is then read through the single read port of the coefficient
// RAM and held while the output is stalled.
// in_stall is high from the 64th coefficient until the last sample transfers.
// Reset clears control state and sample_reg; RAM contents are written before use.
// ----------------------------------------------------------------------------
module idct_8x8_two_dimensional (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [idct_pkg::COEFF_WIDTH-1:0] coefficient,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    output logic signed [idct_pkg::OUT_WIDTH-1:0] sample,
    output logic                                  last_of_block,
    output logic                                  out_valid,
    input  logic                                  out_stall
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_CALC,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t              state_reg;
    logic [5:0]          load_count_reg;
    logic                col_pass_reg;
    logic [2:0]          line_reg;
    logic [3:0]          k_reg;
    logic [5:0]          out_idx_reg;
    logic [idct_pkg::OUT_WIDTH-1:0] sample_reg;
    logic                last_reg;
    logic                out_valid_reg;

    idct_pkg::vw_t line_val [8];
    idct_pkg::vw_t s1_a [8];
    idct_pkg::vw_t s1_m [4];
    idct_pkg::vw_t s2_b [8];
    idct_pkg::vw_t s3_c [4];
    idct_pkg::vw_t s3_m [8];
    idct_pkg::vw_t x_out [8];

    // ram ports
    logic                   c_wr_en;
    logic [5:0]             c_wr_addr;
    logic [idct_pkg::SW-1:0] c_wr_data;
    logic [5:0]             c_rd_addr;
    logic [idct_pkg::SW-1:0] c_rd_data;
    logic                   t_wr_en;
    logic [5:0]             t_wr_addr;
    logic [5:0]             t_rd_addr;
    logic [idct_pkg::VW-1:0] t_rd_data;

    logic          in_xfer;
    logic          out_xfer;
    logic [2:0]    cap_idx;
    idct_pkg::vw_t cap_val;
    idct_pkg::vw_t c_scaled;

    assign in_xfer  = in_valid && (state_reg == ST_LOAD);
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_LOAD);

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign last_of_block = last_reg;

    // ram address and data steering
    always_comb
    begin
        c_wr_en   = 1'b0;
        c_wr_addr = load_count_reg;
        c_wr_data = idct_pkg::SW'(coefficient);
        c_rd_addr = {line_reg, k_reg[2:0]};
        t_wr_en   = 1'b0;
        t_wr_addr = {k_reg[2:0], line_reg};
        t_rd_addr = {line_reg, k_reg[2:0]};
        case (state_reg)
            ST_LOAD:
            begin
                c_wr_en = in_xfer;
            end
            ST_WRITE:
            begin
                if (col_pass_reg)
                begin
                    c_wr_en   = 1'b1;
                    c_wr_addr = {k_reg[2:0], line_reg};
                    c_wr_data = idct_pkg::finish(x_out[k_reg[2:0]]);
                end
                else
                begin
                    t_wr_en = 1'b1;
                end
            end
            ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT:
            begin
                c_rd_addr = out_idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    idct_ram #(
        .WIDTH(idct_pkg::SW),
        .DEPTH(64)
    ) u_coeff_ram (
        .clk     (clk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data)
    );

    idct_ram #(
        .WIDTH(idct_pkg::VW),
        .DEPTH(64)
    ) u_transpose_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (x_out[k_reg[2:0]]),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    // read data capture into the line registers
    assign cap_idx  = 3'(k_reg - 4'd1);
    assign c_scaled = idct_pkg::vw_t'($signed(c_rd_data[idct_pkg::COEFF_WIDTH-1:0]))
                      <<< idct_pkg::FRACTION_BITS;
    assign cap_val  = col_pass_reg ? idct_pkg::vw_t'(t_rd_data) : c_scaled;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ && k_reg != 4'd0)
        begin
            line_val[cap_idx] <= cap_val;
        end
    end

    // butterfly pipeline stage 1: input butterflies and first products
    always_ff @(posedge clk)
    begin
        s1_a[0] <= line_val[0] + line_val[4];
        s1_a[1] <= line_val[0] - line_val[4];
        s1_a[2] <= '0;
        s1_a[3] <= '0;
        s1_a[4] <= line_val[1] - line_val[7];
        s1_a[5] <= idct_pkg::cmul(line_val[3], idct_pkg::K_S);
        s1_a[6] <= idct_pkg::cmul(line_val[5], idct_pkg::K_S);
        s1_a[7] <= line_val[1] + line_val[7];
        s1_m[0] <= idct_pkg::cmul(line_val[2], idct_pkg::K_A);
        s1_m[1] <= idct_pkg::cmul(line_val[6], idct_pkg::K_B);
        s1_m[2] <= idct_pkg::cmul(line_val[2], idct_pkg::K_B);
        s1_m[3] <= idct_pkg::cmul(line_val[6], idct_pkg::K_A);
    end

    // stage 2: even part sums and odd butterflies
    always_ff @(posedge clk)
    begin
        s2_b[0] <= s1_a[0] + (s1_m[2] + s1_m[3]);
        s2_b[1] <= s1_a[1] + (s1_m[0] - s1_m[1]);
        s2_b[2] <= s1_a[1] - (s1_m[0] - s1_m[1]);
        s2_b[3] <= s1_a[0] - (s1_m[2] + s1_m[3]);
        s2_b[4] <= s1_a[4] + s1_a[6];
        s2_b[5] <= s1_a[7] - s1_a[5];
        s2_b[6] <= s1_a[4] - s1_a[6];
        s2_b[7] <= s1_a[7] + s1_a[5];
    end

    // stage 3: odd part rotations
    always_ff @(posedge clk)
    begin
        s3_c[0] <= s2_b[0];
        s3_c[1] <= s2_b[1];
        s3_c[2] <= s2_b[2];
        s3_c[3] <= s2_b[3];
        s3_m[0] <= idct_pkg::cmul(s2_b[4], idct_pkg::K_N);
        s3_m[1] <= idct_pkg::cmul(s2_b[7], idct_pkg::K_T);
        s3_m[2] <= idct_pkg::cmul(s2_b[5], idct_pkg::K_D);
        s3_m[3] <= idct_pkg::cmul(s2_b[6], idct_pkg::K_E);
        s3_m[4] <= idct_pkg::cmul(s2_b[6], idct_pkg::K_D);
        s3_m[5] <= idct_pkg::cmul(s2_b[5], idct_pkg::K_E);
        s3_m[6] <= idct_pkg::cmul(s2_b[7], idct_pkg::K_N);
        s3_m[7] <= idct_pkg::cmul(s2_b[4], idct_pkg::K_T);
    end

    // stage 4: output butterflies
    always_ff @(posedge clk)
    begin
        x_out[0] <= s3_c[0] + (s3_m[6] + s3_m[7]);
        x_out[1] <= s3_c[1] + (s3_m[4] + s3_m[5]);
        x_out[2] <= s3_c[2] + (s3_m[2] - s3_m[3]);
        x_out[3] <= s3_c[3] + (s3_m[0] - s3_m[1]);
        x_out[4] <= s3_c[3] - (s3_m[0] - s3_m[1]);
        x_out[5] <= s3_c[2] - (s3_m[2] - s3_m[3]);
        x_out[6] <= s3_c[1] - (s3_m[4] + s3_m[5]);
        x_out[7] <= s3_c[0] - (s3_m[6] + s3_m[7]);
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            col_pass_reg   <= 1'b0;
            line_reg       <= '0;
            k_reg          <= '0;
            out_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            sample_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        load_count_reg <= load_count_reg + 6'd1;
                        if (load_count_reg == 6'd63)
                        begin
                            state_reg    <= ST_READ;
                            col_pass_reg <= 1'b0;
                            line_reg     <= '0;
                            k_reg        <= '0;
                        end
                    end
                end
                ST_READ:
                begin
                    if (k_reg == 4'd8)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_CALC;
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_CALC:
                begin
                    if (k_reg == 4'd3)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_WRITE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_WRITE:
                begin
                    if (k_reg == 4'd7)
                    begin
                        k_reg    <= '0;
                        line_reg <= line_reg + 3'd1;
                        if (line_reg == 3'd7 && col_pass_reg)
                        begin
                            out_idx_reg <= '0;
                            state_reg   <= ST_OUT_RD;
                        end
                        else
                        begin
                            if (line_reg == 3'd7)
                            begin
                                col_pass_reg <= 1'b1;
                            end
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    sample_reg    <= c_rd_data[idct_pkg::OUT_WIDTH-1:0];
                    last_reg      <= (out_idx_reg == 6'd63);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        out_idx_reg   <= out_idx_reg + 6'd1;
                        if (out_idx_reg == 6'd63)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- rtl/idct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_checker
// Port-level checks of the 8x8 inverse DCT, bound to the top level.
// ----------------------------------------------------------------------------
module idct_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic signed [idct_pkg::OUT_WIDTH-1:0] sample,
    input logic                                  last_of_block,
    input logic                                  out_valid,
    input logic                                  out_stall
);

    // no input transfer while a sample is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
    else $error("input open while output valid");

    // an input transfer never meets a pending sample
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
    else $error("input transfer while output valid");

    // a stalled sample holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last_of_block))
    else $error("stalled sample changed");

    // after the last sample transfers, the block takes input again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_of_block |=> !out_valid && !in_stall)
    else $error("block did not return to loading");

    // a transfer that is not the last keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_block |=> in_stall)
    else $error("input opened in the middle of a block");

endmodule

bind idct_8x8_two_dimensional idct_checker u_idct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .last_of_block (last_of_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
);

// ----- dv/idct_8x8_two_dimensional_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_8x8_two_dimensional_checker
// Watches both channels of the 8x8 inverse DCT, computes the expected
// samples of every completed block and compares each output transfer.
// ----------------------------------------------------------------------------
module idct_8x8_two_dimensional_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [idct_pkg::COEFF_WIDTH-1:0] coefficient,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [idct_pkg::OUT_WIDTH-1:0]   sample,
    input  logic                                    last_of_block,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    output int                                      fail_count,
    output int                                      pending
);

    localparam int FB = idct_pkg::FRACTION_BITS;
    localparam int OW = idct_pkg::OUT_WIDTH;

    typedef struct packed {
        logic signed [OW-1:0] value;
        logic                 last;
    } pixel_t;

    typedef longint line_t [8];

    longint block_coeffs [64];
    int     coeff_index;
    pixel_t expected_pixels [$];

    // fixed-point constants rounded from 30 fractional bits
    function automatic longint to_frac(input longint k30);
        return (k30 + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    endfunction

    // product rounded half up back to the working fraction
    function automatic longint scale_mul(input longint v, input longint k);
        return (v * k + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    // one 8-point butterfly inverse transform
    function automatic line_t butterfly(input line_t x);
        longint ks, ka, kb, kd, ke, kn, kt;
        longint a4, a5, a6, a7, b0, b1, b2, b3, b4, b5, b6, b7;
        longint c0, c1, c2, c3, c4, c5, c6, c7;
        line_t y;
        ks = to_frac(64'sd1518500250); ka = to_frac(64'sd581104888);
        kb = to_frac(64'sd1402911301); kd = to_frac(64'sd1053110176);
        ke = to_frac(64'sd209476638);  kn = to_frac(64'sd892783698);
        kt = to_frac(64'sd596538995);
        a4 = x[1] - x[7]; a5 = scale_mul(x[3], ks);
        a6 = scale_mul(x[5], ks); a7 = x[1] + x[7];
        b0 = x[0] + x[4]; b1 = x[0] - x[4];
        b2 = scale_mul(x[2], ka) - scale_mul(x[6], kb);
        b3 = scale_mul(x[2], kb) + scale_mul(x[6], ka);
        b4 = a4 + a6; b5 = a7 - a5; b6 = a4 - a6; b7 = a7 + a5;
        c0 = b0 + b3; c1 = b1 + b2; c2 = b1 - b2; c3 = b0 - b3;
        c4 = scale_mul(b4, kn) - scale_mul(b7, kt);
        c5 = scale_mul(b5, kd) - scale_mul(b6, ke);
        c6 = scale_mul(b6, kd) + scale_mul(b5, ke);
        c7 = scale_mul(b7, kn) + scale_mul(b4, kt);
        y[0] = c0 + c7; y[1] = c1 + c6; y[2] = c2 + c5; y[3] = c3 + c4;
        y[4] = c3 - c4; y[5] = c2 - c5; y[6] = c1 - c6; y[7] = c0 - c7;
        return y;
    endfunction

    // remove the fraction bits and divide by 8 toward zero, then clamp
    function automatic logic signed [OW-1:0] to_pixel(input longint v);
        longint q;
        q = (v >= 0) ? (v >>> (FB + 3)) : -((-v) >>> (FB + 3));
        if (q > 2047)
            q = 2047;
        if (q < -2048)
            q = -2048;
        return q[OW-1:0];
    endfunction

    // row pass, transpose, column pass; queue samples in row-major order
    task automatic predict_block();
        longint transposed [64];
        pixel_t pixels [64];
        line_t row;
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
                row[k] = block_coeffs[r*8 + k] * (64'sd1 <<< FB);
            row = butterfly(row);
            for (int k = 0; k < 8; k++)
                transposed[k*8 + r] = row[k];
        end
        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < 8; k++)
                row[k] = transposed[c*8 + k];
            row = butterfly(row);
            for (int k = 0; k < 8; k++)
            begin
                pixels[k*8 + c].value = to_pixel(row[k]);
                pixels[k*8 + c].last  = (k*8 + c == 63);
            end
        end
        for (int i = 0; i < 64; i++)
            expected_pixels.push_back(pixels[i]);
    endtask

    assign pending = expected_pixels.size();

    // track input transfers and check output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_index <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                block_coeffs[coeff_index] = coefficient;
                if (coeff_index == 63)
                begin
                    predict_block();
                    coeff_index <= 0;
                end
                else
                    coeff_index <= coeff_index + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected sample transfer: %0d last %0b",
                                 sample, last_of_block);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    pixel_t exp_px;
                    exp_px = expected_pixels.pop_front();
                    if (sample !== exp_px.value || last_of_block !== exp_px.last)
                    begin
                        if (fail_count < 10)
                            $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                     exp_px.value, exp_px.last, sample, last_of_block);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/idct_8x8_two_dimensional_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_8x8_two_dimensional_tb
// Feeds directed and random 8x8 coefficient blocks with random idle and
// stall cycles; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module idct_8x8_two_dimensional_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CW          = idct_pkg::COEFF_WIDTH;
    localparam int OW          = idct_pkg::OUT_WIDTH;

    logic                 clk;
    logic                 rst_n;
    logic signed [CW-1:0] coefficient;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [OW-1:0] sample;
    logic                 last_of_block;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    bit                   calm;

    idct_8x8_two_dimensional dut (.*);

    idct_8x8_two_dimensional_checker checker_i (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // random receiver stall, with a calm stretch
    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 23);

    // one coefficient transfer, with random idle cycles before it
    task automatic send_coeff(input logic signed [CW-1:0] c);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        coefficient <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // coefficients of one kind: 0 random sparse, 1 dense random, 2 all max,
    // 3 all min, 4 dc only, 5 alternating extremes
    task automatic send_block(input int kind, input int count);
        logic signed [CW-1:0] c;
        for (int i = 0; i < count; i++)
        begin
            case (kind)
                0: c = ($urandom_range(3) == 0) ? CW'($urandom) :
                       ((i < 6) ? CW'(int'($urandom_range(255)) - 128) : '0);
                1: c = CW'($urandom);
                2: c = 12'sd2047;
                3: c = -12'sd2048;
                4: c = (i == 0) ? (($urandom_range(1)) ? 12'sd2047 : -12'sd2048) : 12'sd0;
                default: c = ((i ^ (i >> 3)) & 1) ? 12'sd2047 : -12'sd2048;
            endcase
            send_coeff(c);
        end
    endtask

    initial
    begin
        int waited;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        coefficient = '0;
        calm        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturating extremes, then a dense block with no idling
        send_block(5, 64);
        calm = 1'b1;
        send_block(1, 64);
        calm = 1'b0;
        // sparse random block, then a partial block that never completes
        send_block(0, 64);
        send_block(2, 8);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        waited = 0;
        while (waited < 50)
        begin
            @(posedge clk);
            waited++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
